/* sv/sbs_pkg.sv */
// shared types and constants for the sorted table binary search block
// depends on nothing; imported by sbs_datapath, sbs_ctrl and the top module
`timescale 1ns / 1ps

package sbs_pkg;

    // table geometry
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    // fixed field widths
    localparam int KEY_W  = 32;
    localparam int IDX_W  = 10;
    localparam int CFG_W  = 11;
    localparam int POS_W  = 10;

    // item commands
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PROBE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic wr_en;    // store key of a load beat
        logic init;     // capture key and open the search range
        logic rd_en;    // read the table at the current or next midpoint
        logic step;     // narrow the range after a miss on the probe
        logic finish;   // capture the result
        logic found;    // result flag captured with finish
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic empty;      // search range is empty
        logic hit;        // probed entry equals the key
        logic next_empty; // range after this probe would be empty
    } t_dp_status;

endpackage

/* sv/sbs_ram.sv */
// generic simple dual port ram with registered read
// no dependencies; used for the key table
`timescale 1ns / 1ps

module sbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/sbs_datapath.sv */
// datapath: entry count register, key table, search range and result registers
// depends on sbs_pkg and sbs_ram
`timescale 1ns / 1ps

module sbs_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sbs_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic [sbs_pkg::IDX_W-1:0]      i_entry_index,
    input  logic signed [sbs_pkg::KEY_W-1:0] i_key_value,
    input  sbs_pkg::t_dp_cmd               i_ctl,
    output sbs_pkg::t_dp_status            o_status,
    output logic                           o_found,
    output logic [sbs_pkg::POS_W-1:0]      o_position
);

    import sbs_pkg::*;

    logic [CFG_W-1:0]  r_count;
    logic [KEY_W-1:0]  r_key;
    logic [CNT_W-1:0]  r_lo;
    logic [CNT_W-1:0]  r_hi;      // exclusive upper bound
    logic [ADDR_W-1:0] r_mid;
    logic              r_found;
    logic [POS_W-1:0]  r_pos;

    logic [CNT_W-1:0]  eff_count;
    logic [ADDR_W-1:0] init_mid;
    logic [ADDR_W-1:0] gt_mid;
    logic [ADDR_W-1:0] lt_mid;
    logic              gt_empty;
    logic              lt_empty;
    logic              key_gt;
    logic              key_eq;
    logic              wr_ok;
    logic [ADDR_W-1:0] rd_addr;
    logic [KEY_W-1:0]  rd_data;

    // entry count register; the count used for searches is saturated at the table depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    assign eff_count = (32'(r_count) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(r_count);
    assign init_mid  = ADDR_W'((eff_count - CNT_W'(1)) >> 1);

    // candidate next midpoints, worked out in parallel with the compare
    assign gt_mid   = ADDR_W'((SUM_W'(r_mid) + SUM_W'(r_hi)) >> 1);
    assign lt_mid   = ADDR_W'((SUM_W'(r_lo) + SUM_W'(r_mid) - SUM_W'(1)) >> 1);
    assign gt_empty = !((CNT_W'(r_mid) + CNT_W'(1)) < r_hi);
    assign lt_empty = !(r_lo < CNT_W'(r_mid));

    // probe compare
    assign key_eq = (r_key == rd_data);
    assign key_gt = ($signed(r_key) > $signed(rd_data));

    assign o_status.empty      = (r_hi == '0);
    assign o_status.hit        = key_eq;
    assign o_status.next_empty = key_gt ? gt_empty : lt_empty;

    // search range registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_key <= i_key_value;
            r_lo  <= '0;
            r_hi  <= eff_count;
            r_mid <= init_mid;
        end else if (i_ctl.step) begin
            if (key_gt) begin
                r_lo  <= CNT_W'(r_mid) + CNT_W'(1);
                r_mid <= gt_mid;
            end else begin
                r_hi  <= CNT_W'(r_mid);
                r_mid <= lt_mid;
            end
        end
    end

    // key table; loads beyond the depth are dropped
    assign wr_ok   = i_ctl.wr_en && (32'(i_entry_index) < DEPTH);
    assign rd_addr = i_ctl.step ? (key_gt ? gt_mid : lt_mid) : r_mid;

    sbs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_key_table (
        .i_clk   (i_clk),
        .i_we    (wr_ok),
        .i_waddr (ADDR_W'(i_entry_index)),
        .i_wdata (i_key_value),
        .i_re    (i_ctl.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_found <= i_ctl.found;
            r_pos   <= i_ctl.found ? POS_W'(r_mid) : '0;
        end
    end

    assign o_found    = r_found;
    assign o_position = r_pos;

endmodule

/* sv/sbs_ctrl.sv */
// controller state machine for the binary search
// depends on sbs_pkg
`timescale 1ns / 1ps

module sbs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_cmd,
    input  sbs_pkg::t_dp_status i_status,
    output sbs_pkg::t_dp_cmd    o_ctl,
    output logic                o_busy,
    output logic                o_done
);

    import sbs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;

    // state and strobe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_cmd == CMD_SEARCH) begin
                        o_ctl.init = 1'b1;
                        n_state    = ST_SETUP;
                    end else begin
                        o_ctl.wr_en = 1'b1;
                    end
                end
            end
            ST_SETUP: begin
                if (i_status.empty) begin
                    o_ctl.finish = 1'b1;
                    n_done       = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_ctl.rd_en = 1'b1;
                    n_state     = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (i_status.hit) begin
                    o_ctl.finish = 1'b1;
                    o_ctl.found  = 1'b1;
                    n_done       = 1'b1;
                    n_state      = ST_IDLE;
                end else if (i_status.next_empty) begin
                    o_ctl.finish = 1'b1;
                    n_done       = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_ctl.step  = 1'b1;
                    o_ctl.rd_en = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;

endmodule

/* sv/sorted_table_binary_search.sv */
// binary search over a sorted key table; load beats are written from idle, busy stays low
// a search strobes its result after its last probe; its probe count P is at most
// log2(depth)+1 (11 for 1024 entries); one table read per probe sets the pace
// a new beat is taken in the cycle the result is strobed; results cannot be stalled
// synchronous active-low reset clears the entry count and control; the table
// holds no reset value and needs no clearing pass
`timescale 1ns / 1ps

module sorted_table_binary_search (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sbs_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_cmd,
    input  logic [sbs_pkg::IDX_W-1:0]        i_entry_index,
    input  logic signed [sbs_pkg::KEY_W-1:0] i_key_value,
    output logic                             o_done,
    output logic                             o_found,
    output logic [sbs_pkg::POS_W-1:0]        o_position
);

    import sbs_pkg::*;

    t_dp_cmd    ctl;
    t_dp_status status;

    // sequencing
    sbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_status (status),
        .o_ctl    (ctl),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    // table and search datapath
    sbs_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_entry_index (i_entry_index),
        .i_key_value   (i_key_value),
        .i_ctl         (ctl),
        .o_status      (status),
        .o_found       (o_found),
        .o_position    (o_position)
    );

    // a miss reports position zero
    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_found) |-> (o_position == '0))
        else $error("miss result with nonzero position");

    // one strobe per search
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // an accepted search keeps the block busy
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd == CMD_SEARCH)) |=> busy)
        else $error("search accepted but block not busy");

    // a result follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a search in flight");

    // a load leaves the block idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd == CMD_LOAD)) |=> (!busy && !o_done))
        else $error("load beat started a search");

endmodule
